FILE: hw/rtl/obpl_pkg.sv
// Shared types and constants for the order book price-level table.
package obpl_pkg;

   // Table geometry.
   localparam int LEVELS = 64;
   localparam int TOP    = 5;

   // Field widths.
   localparam int PRICE_W = 32;
   localparam int QTY_W   = 48;
   localparam int RANK_W  = 3;
   localparam int SLOT_W  = (TOP > 1) ? $clog2(TOP) : 1;

   // Stream packing widths.
   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 88;

   // Request kinds.
   localparam logic OP_UPDATE   = 1'b0;
   localparam logic OP_SNAPSHOT = 1'b1;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_APPLY,
      ST_SNAP
   } state_type;

   // One price level as held by a cell.
   typedef struct packed {
      logic               valid;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } lvl_type;

   localparam lvl_type LVL_EMPTY = '{valid: 1'b0, price: '0, qty: '0};

   // Accepted request.
   typedef struct packed {
      logic               opcode;
      logic               is_bid;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } cmd_type;

   // Update broadcast from the controller to one side.
   typedef struct packed {
      logic               compare;
      logic               apply;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } upd_type;

   // Operation chosen for one side during the apply cycle.
   typedef struct packed {
      logic set;
      logic del;
      logic ins;
   } cell_op_type;

endpackage

FILE: hw/rtl/obpl_cell.sv
// One price-level cell: holds a level, compares it, and shifts with its neighbors.
module obpl_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 side_bid,
   input  obpl_pkg::upd_type    upd,
   input  obpl_pkg::cell_op_type op,
   input  logic                 left_ahead,
   input  obpl_pkg::lvl_type    left_lvl,
   input  obpl_pkg::lvl_type    right_lvl,
   output obpl_pkg::lvl_type    lvl,
   output logic                 ahead,
   output logic                 match
);
   import obpl_pkg::*;

   logic               valid_ff, valid_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [QTY_W-1:0]   qty_ff, qty_in;
   logic               ahead_ff, ahead_in;
   logic               match_ff, match_in;

   assign lvl   = '{valid: valid_ff, price: price_ff, qty: qty_ff};
   assign ahead = ahead_ff;
   assign match = match_ff;

   // Compare the held level against the broadcast price.
   always_comb begin
      ahead_in = ahead_ff;
      match_in = match_ff;
      if (upd.compare) begin
         ahead_in = valid_ff && (side_bid ? (price_ff > upd.price) : (price_ff < upd.price));
         match_in = valid_ff && (price_ff == upd.price);
      end
   end

   // Next level: replace quantity, shift left on removal, shift right on insertion.
   always_comb begin
      valid_in = valid_ff;
      price_in = price_ff;
      qty_in   = qty_ff;
      if (op.set && match_ff) begin
         qty_in = upd.qty;
      end else if (op.del && !ahead_ff) begin
         valid_in = right_lvl.valid;
         price_in = right_lvl.price;
         qty_in   = right_lvl.qty;
      end else if (op.ins) begin
         if (left_ahead && !ahead_ff) begin
            valid_in = 1'b1;
            price_in = upd.price;
            qty_in   = upd.qty;
         end else if (!left_ahead) begin
            valid_in = left_lvl.valid;
            price_in = left_lvl.price;
            qty_in   = left_lvl.qty;
         end
      end
   end

   // Control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ahead_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         ahead_ff <= ahead_in;
         match_ff <= match_in;
      end
   end

   // Level payload.
   always_ff @(posedge clock) begin
      price_ff <= price_in;
      qty_ff   <= qty_in;
   end

endmodule

FILE: hw/rtl/obpl_side.sv
// One side of the book: a chain of level cells kept best first.
module obpl_side (
   input  logic              clock,
   input  logic              reset,
   input  logic              side_bid,
   input  obpl_pkg::upd_type upd,
   output obpl_pkg::lvl_type top_lvl [obpl_pkg::TOP]
);
   import obpl_pkg::*;

   lvl_type           lvl [LEVELS];
   lvl_type           left_lvl [LEVELS];
   lvl_type           right_lvl [LEVELS];
   logic [LEVELS-1:0] ahead;
   logic [LEVELS-1:0] left_ahead;
   logic [LEVELS-1:0] match;
   logic              found;
   logic              qty_zero;
   cell_op_type       op;

   // The matching cell, if any, decides between replace, remove and insert.
   assign found    = |match;
   assign qty_zero = (upd.qty == '0);

   always_comb begin
      op.set = upd.apply && !qty_zero && found;
      op.del = upd.apply && qty_zero && found;
      op.ins = upd.apply && !qty_zero && !found;
   end

   // Chain of cells with neighbor links.
   for (genvar i = 0; i < LEVELS; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_lvl[i]   = LVL_EMPTY;
         assign left_ahead[i] = 1'b1;
      end else begin : g_mid
         assign left_lvl[i]   = lvl[i-1];
         assign left_ahead[i] = ahead[i-1];
      end
      if (i == LEVELS - 1) begin : g_last
         assign right_lvl[i] = LVL_EMPTY;
      end else begin : g_inner
         assign right_lvl[i] = lvl[i+1];
      end

      obpl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .side_bid   (side_bid),
         .upd        (upd),
         .op         (op),
         .left_ahead (left_ahead[i]),
         .left_lvl   (left_lvl[i]),
         .right_lvl  (right_lvl[i]),
         .lvl        (lvl[i]),
         .ahead      (ahead[i]),
         .match      (match[i])
      );
   end

   // Best levels for the snapshot.
   for (genvar k = 0; k < TOP; k++) begin : g_top
      if (k < LEVELS) begin : g_have
         assign top_lvl[k] = lvl[k];
      end else begin : g_none
         assign top_lvl[k] = LVL_EMPTY;
      end
   end

endmodule

FILE: hw/rtl/obpl_ctrl.sv
// Sequencer: takes requests, steps updates through compare and apply, streams snapshots.
module obpl_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  obpl_pkg::cmd_type             req_cmd,
   output obpl_pkg::upd_type             bid_upd,
   output obpl_pkg::upd_type             ask_upd,
   input  obpl_pkg::lvl_type             bid_top [obpl_pkg::TOP],
   input  obpl_pkg::lvl_type             ask_top [obpl_pkg::TOP],
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_side,
   output logic [obpl_pkg::RANK_W-1:0]   rsp_rank,
   output logic [obpl_pkg::PRICE_W-1:0]  rsp_price,
   output logic [obpl_pkg::QTY_W-1:0]    rsp_qty,
   output logic                          rsp_last
);
   import obpl_pkg::*;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff;
   logic               snap_bid_ff, snap_bid_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_side_ff;
   logic [RANK_W-1:0]  out_rank_ff;
   logic [PRICE_W-1:0] out_price_ff;
   logic [QTY_W-1:0]   out_qty_ff;
   logic               out_last_ff;
   logic               accept;
   logic               load;
   logic               slot_end;
   logic               snap_last;
   lvl_type            pick;

   assign accept    = req_valid && req_ready;
   assign slot_end  = (slot_ff == SLOT_W'(TOP - 1));
   assign snap_last = !snap_bid_ff && slot_end;
   assign load      = (state_ff == ST_SNAP) && (!out_valid_ff || rsp_ready);
   assign pick      = snap_bid_ff ? bid_top[slot_ff] : ask_top[slot_ff];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE, ST_APPLY: begin
            if (accept) begin
               state_in = (req_cmd.opcode == OP_SNAPSHOT) ? ST_SNAP : ST_COMPARE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_COMPARE: state_in = ST_APPLY;
         ST_SNAP: begin
            if (load && snap_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs: handshake and update strobes.
   always_comb begin
      req_ready       = 1'b0;
      bid_upd.compare = 1'b0;
      bid_upd.apply   = 1'b0;
      case (state_ff)
         ST_IDLE:    req_ready = 1'b1;
         ST_COMPARE: bid_upd.compare = 1'b1;
         ST_APPLY: begin
            req_ready     = 1'b1;
            bid_upd.apply = 1'b1;
         end
         ST_SNAP:    req_ready = 1'b0;
         default:    req_ready = 1'b0;
      endcase
      bid_upd.price   = cmd_ff.price;
      bid_upd.qty     = cmd_ff.qty;
      ask_upd         = bid_upd;
      bid_upd.compare = bid_upd.compare && cmd_ff.is_bid;
      bid_upd.apply   = bid_upd.apply && cmd_ff.is_bid;
      ask_upd.compare = ask_upd.compare && !cmd_ff.is_bid;
      ask_upd.apply   = ask_upd.apply && !cmd_ff.is_bid;
   end

   // Snapshot walk: bid slots first, then ask slots.
   always_comb begin
      snap_bid_in = snap_bid_ff;
      slot_in     = slot_ff;
      if (accept) begin
         snap_bid_in = 1'b1;
         slot_in     = '0;
      end else if (load) begin
         if (slot_end) begin
            snap_bid_in = 1'b0;
            slot_in     = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   // Output beat register.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         snap_bid_ff  <= 1'b1;
         slot_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         snap_bid_ff  <= snap_bid_in;
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Request and result payloads.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
      end
      if (load) begin
         out_side_ff  <= snap_bid_ff;
         out_rank_ff  <= RANK_W'(slot_ff);
         out_price_ff <= pick.valid ? pick.price : '0;
         out_qty_ff   <= pick.valid ? pick.qty : '0;
         out_last_ff  <= snap_last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_side  = out_side_ff;
   assign rsp_rank  = out_rank_ff;
   assign rsp_price = out_price_ff;
   assign rsp_qty   = out_qty_ff;
   assign rsp_last  = out_last_ff;

endmodule

FILE: hw/rtl/order_book_price_levels_core.sv
// Order book price-level table: top level with request and result streams.
//
// Requests arrive on the req_ stream. A beat with tuser opcode 0 updates one
// side: quantity zero removes the level at that price, any other quantity
// replaces that level's quantity or inserts a new level in price order, and
// a full side drops its worst level (or the new one, if it is worst).
// A beat with opcode 1 asks for a snapshot: the rsp_ stream then carries the
// TOP best bids, then the TOP best asks, empty slots zero, tlast on the last.
// Each side is a chain of 64 level cells; every cell compares its own price
// with the broadcast one, then all cells shift or load together.
// An update steps through compare, then apply, and the next request is
// taken in the apply cycle. An update gives no result beat.
// A snapshot moves the controller to its snap state, which loads the first
// beat into the result register, then one beat per cycle while rsp_tready is
// high. A stalled receiver holds the result register and the walk;
// a waiting last beat does not block the next request.
// Synchronous reset empties both sides.
module order_book_price_levels_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [obpl_pkg::REQ_DATA_W-1:0]    req_tdata,  // price, quantity
   input  logic [obpl_pkg::REQ_USER_W-1:0]    req_tuser,  // opcode, is_bid
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [obpl_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // level_rank, level_price, level_qty
   output logic [0:0]                         rsp_tuser,  // book_side
   output logic                               rsp_tlast
);
   import obpl_pkg::*;

   cmd_type            req_cmd;
   upd_type            bid_upd;
   upd_type            ask_upd;
   lvl_type            bid_top [TOP];
   lvl_type            ask_top [TOP];
   logic               rsp_side;
   logic [RANK_W-1:0]  rsp_rank;
   logic [PRICE_W-1:0] rsp_price;
   logic [QTY_W-1:0]   rsp_qty;

   // Unpack the request beat.
   assign req_cmd.opcode = req_tuser[0];
   assign req_cmd.is_bid = req_tuser[1];
   assign req_cmd.price  = req_tdata[PRICE_W-1:0];
   assign req_cmd.qty    = req_tdata[PRICE_W+QTY_W-1:PRICE_W];

   obpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_cmd),
      .bid_upd   (bid_upd),
      .ask_upd   (ask_upd),
      .bid_top   (bid_top),
      .ask_top   (ask_top),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_side  (rsp_side),
      .rsp_rank  (rsp_rank),
      .rsp_price (rsp_price),
      .rsp_qty   (rsp_qty),
      .rsp_last  (rsp_tlast)
   );

   obpl_side u_bid (
      .clock    (clock),
      .reset    (reset),
      .side_bid (1'b1),
      .upd      (bid_upd),
      .top_lvl  (bid_top)
   );

   obpl_side u_ask (
      .clock    (clock),
      .reset    (reset),
      .side_bid (1'b0),
      .upd      (ask_upd),
      .top_lvl  (ask_top)
   );

   // Pack the result beat, zero-filled to whole bytes.
   assign rsp_tdata = {{(RSP_DATA_W - RANK_W - PRICE_W - QTY_W){1'b0}},
                       rsp_qty, rsp_price, rsp_rank};
   assign rsp_tuser = rsp_side;

endmodule

FILE: hw/rtl/obpl_checker.sv
// Port-level checks for the order book price-level table, bound to the top level.
module obpl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [obpl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [0:0]                      rsp_tuser,
   input logic                            rsp_tlast
);
   import obpl_pkg::*;

   // Reset leaves no result beat pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat present after reset");

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // Every request keeps the block busy for the following cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on back-to-back cycles");

   // The last snapshot beat is the worst ask slot shown.
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0] == 1'b0 &&
      rsp_tdata[RANK_W-1:0] == RANK_W'(TOP - 1))
      else $error("end of snapshot on the wrong slot");

endmodule

bind order_book_price_levels_core obpl_checker u_obpl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: test/order_book_price_levels_core_tb.sv
// Testbench for the order book price-level table: stream stimulus, prediction and result checks.
module order_book_price_levels_core_tb;
   import obpl_pkg::*;

   // One snapshot slot as it should appear on the result stream.
   typedef struct packed {
      logic               side;
      logic [RANK_W-1:0]  rank;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
      logic               last;
   } book_slot_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // price, quantity
   logic [REQ_USER_W-1:0] req_tuser = '0;  // opcode, is_bid
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // level_rank, level_price, level_qty
   logic [0:0]            rsp_tuser;       // book_side
   logic                  rsp_tlast;

   // Predicted book: index 1 holds the bids, index 0 the asks, best level first.
   logic [PRICE_W-1:0] book_price [2][LEVELS];
   logic [QTY_W-1:0]   book_qty   [2][LEVELS];
   int                 book_depth [2];

   book_slot_type slots_due[$];
   int            mismatches = 0;

   // Idling controls for both sides of the block.
   bit req_idle_en = 1'b0;
   bit rsp_idle_en = 1'b0;
   logic rsp_hold = 1'b0;
   int rsp_stall_left = 0;
   int rsp_pick;

   order_book_price_levels_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one level update to the predicted book.
   function automatic void book_update(logic bid, logic [PRICE_W-1:0] price,
                                       logic [QTY_W-1:0] qty);
      int s;
      int n;
      int pos;
      bit found;
      s = bid ? 1 : 0;
      n = book_depth[s];
      pos = 0;
      while (pos < n && (bid ? (book_price[s][pos] > price) : (book_price[s][pos] < price)))
         pos++;
      found = (pos < n) && (book_price[s][pos] == price);
      if (qty == '0) begin
         if (!found)
            return;
         for (int k = pos; k + 1 < n; k++) begin
            book_price[s][k] = book_price[s][k+1];
            book_qty[s][k]   = book_qty[s][k+1];
         end
         book_price[s][n-1] = '0;
         book_qty[s][n-1]   = '0;
         book_depth[s] = n - 1;
         return;
      end
      if (found) begin
         book_qty[s][pos] = qty;
         return;
      end
      // A full side drops its worst level, or the new one if that is worse still.
      if (n >= LEVELS) begin
         if (pos >= LEVELS)
            return;
         n = LEVELS - 1;
      end
      for (int k = n; k > pos; k--) begin
         book_price[s][k] = book_price[s][k-1];
         book_qty[s][k]   = book_qty[s][k-1];
      end
      book_price[s][pos] = price;
      book_qty[s][pos]   = qty;
      book_depth[s] = n + 1;
   endfunction

   // Queue the top slots of the bid side, then of the ask side.
   function automatic void book_snapshot();
      book_slot_type slot;
      int s;
      for (int sn = 0; sn < 2; sn++) begin
         s = (sn == 0) ? 1 : 0;
         for (int i = 0; i < TOP; i++) begin
            slot.side  = s[0];
            slot.rank  = i[RANK_W-1:0];
            slot.price = (i < book_depth[s]) ? book_price[s][i] : '0;
            slot.qty   = (i < book_depth[s]) ? book_qty[s][i] : '0;
            slot.last  = (sn == 1) && (i == TOP - 1);
            slots_due.push_back(slot);
         end
      end
   endfunction

   // Offer one request beat, wait for it to be taken, then predict its effect.
   task automatic send_request(logic op, logic bid, logic [PRICE_W-1:0] price,
                               logic [QTY_W-1:0] qty);
      int r;
      int gap;
      gap = 0;
      if (req_idle_en) begin
         r = $urandom_range(0, 99);
         if (r < 60)
            gap = 0;
         else if (r < 92)
            gap = $urandom_range(1, 3);
         else
            gap = $urandom_range(8, 40);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {bid, op};
      req_tdata  <= {qty, price};
      do @(posedge clock); while (!req_tready);
      if (op == OP_SNAPSHOT)
         book_snapshot();
      else
         book_update(bid, price, qty);
   endtask

   // Stop offering and wait until every predicted slot has come back.
   task automatic wait_book_drained();
      req_tvalid <= 1'b0;
      while (slots_due.size() != 0)
         @(posedge clock);
   endtask

   // Keep the receiver from taking results for the hold length that the caller gives.
   task automatic hold_results(int cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   function automatic logic [PRICE_W-1:0] pick_price();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return PRICE_W'($urandom_range(4990, 5150));
      else if (r < 85)
         return '0;
      else if (r < 90)
         return '1;
      else
         return PRICE_W'($urandom);
   endfunction

   function automatic logic [QTY_W-1:0] pick_qty();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      return wide[QTY_W-1:0];
   endfunction

   // Random request: mostly updates near the resting prices, some removals and snapshots.
   task automatic send_random_request();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15)
         send_request(OP_SNAPSHOT, 1'($urandom), PRICE_W'($urandom), pick_qty());
      else if (r < 45)
         send_request(OP_UPDATE, 1'($urandom), pick_price(), '0);
      else
         send_request(OP_UPDATE, 1'($urandom), pick_price(), pick_qty());
   endtask

   // Result receiver: compare each beat taken with the oldest predicted slot.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (slots_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: side %0d rank %0d price %h qty %h last %0d",
                        rsp_tuser[0], rsp_tdata[2:0], rsp_tdata[34:3], rsp_tdata[82:35],
                        rsp_tlast);
         end else begin
            book_slot_type want;
            want = slots_due.pop_front();
            if (rsp_tuser[0] !== want.side || rsp_tdata[2:0] !== want.rank ||
                rsp_tdata[34:3] !== want.price || rsp_tdata[82:35] !== want.qty ||
                rsp_tlast !== want.last) begin
               mismatches++;
               // Fields in order: side, rank, price, quantity, last.
               if (mismatches <= 10)
                  $display("slot mismatch: expected %0d/%0d/%h/%h/%0d, got %0d/%0d/%h/%h/%0d",
                           want.side, want.rank, want.price, want.qty, want.last,
                           rsp_tuser[0], rsp_tdata[2:0], rsp_tdata[34:3], rsp_tdata[82:35],
                           rsp_tlast);
            end
         end
      end
      // Ready pattern: a long hold wins, then a running stall, then random stalls.
      if (rsp_hold)
         rsp_tready <= 1'b0;
      else if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else if (!rsp_idle_en)
         rsp_tready <= 1'b1;
      else begin
         rsp_pick = $urandom_range(0, 99);
         if (rsp_pick < 70)
            rsp_tready <= 1'b1;
         else begin
            rsp_tready <= 1'b0;
            rsp_stall_left = (rsp_pick < 94) ? $urandom_range(0, 2) : $urandom_range(6, 40);
         end
      end
   end

   // Hand-picked levels: empty book, price extremes, replace, remove present and absent.
   task automatic test_directed();
      send_request(OP_SNAPSHOT, 1'b1, '1, '1);
      send_request(OP_UPDATE, 1'b1, 32'd100, '0);
      send_request(OP_UPDATE, 1'b1, 32'd100, 48'd10);
      send_request(OP_UPDATE, 1'b1, 32'd105, 48'd20);
      send_request(OP_UPDATE, 1'b1, 32'd95, 48'd30);
      send_request(OP_UPDATE, 1'b1, 32'd0, 48'd1);
      send_request(OP_UPDATE, 1'b1, '1, '1);
      send_request(OP_UPDATE, 1'b0, 32'd200, 48'd5);
      send_request(OP_UPDATE, 1'b0, 32'd0, 48'd7);
      send_request(OP_UPDATE, 1'b0, '1, 48'd9);
      send_request(OP_UPDATE, 1'b0, 32'd150, 48'h8000_0000_0001);
      send_request(OP_SNAPSHOT, 1'b0, '0, '0);
      send_request(OP_UPDATE, 1'b1, 32'd100, 48'h5555_5555_5555);
      send_request(OP_UPDATE, 1'b0, 32'd200, 48'hAAAA_AAAA_AAAA);
      send_request(OP_UPDATE, 1'b1, 32'd105, '0);
      send_request(OP_UPDATE, 1'b0, 32'd0, '0);
      send_request(OP_UPDATE, 1'b0, 32'd999, '0);
      send_request(OP_SNAPSHOT, 1'b0, 32'h1234_5678, 48'h1);
      send_request(OP_UPDATE, 1'b1, '1, '0);
      send_request(OP_UPDATE, 1'b1, 32'd100, '0);
      send_request(OP_UPDATE, 1'b1, 32'd95, '0);
      send_request(OP_UPDATE, 1'b1, 32'd0, '0);
      send_request(OP_SNAPSHOT, 1'b1, '0, '0);
      wait_book_drained();
   endtask

   // Fill one side past its depth in scrambled price order, then probe the full table.
   task automatic test_fill_side(logic bid);
      logic [PRICE_W-1:0] base;
      base = bid ? 32'd5001 : 32'd5000;
      for (int i = 0; i < 68; i++) begin
         send_request(OP_UPDATE, bid, base + PRICE_W'(((i * 37) % 68) * 2), QTY_W'(i + 1));
         if (i % 17 == 16)
            send_request(OP_SNAPSHOT, bid, '0, '0);
      end
      send_request(OP_UPDATE, bid, bid ? 32'd1 : 32'd6000, 48'd77);
      send_request(OP_UPDATE, bid, bid ? 32'd9000 : 32'd1, 48'd88);
      send_request(OP_UPDATE, bid, base + 32'd20, '0);
      send_request(OP_UPDATE, bid, base + 32'd20, 48'd99);
      send_request(OP_SNAPSHOT, bid, '0, '0);
   endtask

   // Random traffic against the filled book.
   task automatic test_random(int count);
      repeat (count) send_random_request();
   endtask

   // Receiver holds off while the sender keeps offering, so the block stalls its input.
   task automatic test_backpressure();
      req_idle_en = 1'b0;
      fork
         hold_results(400);
         begin
            repeat (12) begin
               send_request(OP_SNAPSHOT, 1'($urandom), PRICE_W'($urandom), pick_qty());
               send_random_request();
            end
         end
      join
      wait_book_drained();
      repeat (20) @(posedge clock);
   endtask

   initial begin
      for (int s = 0; s < 2; s++) begin
         book_depth[s] = 0;
         for (int i = 0; i < LEVELS; i++) begin
            book_price[s][i] = '0;
            book_qty[s][i]   = '0;
         end
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      test_fill_side(1'b0);
      test_fill_side(1'b1);
      test_random(35);
      wait_book_drained();
      repeat (15) @(posedge clock);
      test_backpressure();
      req_idle_en = 1'b1;
      test_random(25);
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      test_random(10);

      wait_book_drained();
      repeat (30) @(posedge clock);
      if (mismatches == 0)
         $display("order_book_price_levels_core: match");
      else
         $display("order_book_price_levels_core: mismatch");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20000000;
      $display("order_book_price_levels_core: mismatch");
      $finish;
   end

endmodule
